// ===== rtl/assert_macros.svh =====
// Assertion macros used by the histogram top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, suspended while reset is asserted.
`define GLH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked on every rising edge, also during reset.
`define GLH_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/glh_pkg.sv =====
// Types and constants of the grey level histogram.
`default_nettype none
package glh_pkg;

	localparam int LEVEL_W = 8;
	localparam int COUNT_W = 21;
	localparam int OUT_TDATA_W = 24;
	localparam int BIN_COUNT_DEF = 256;
	localparam longint unsigned MAX_PIXELS = 64'd1048576;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [COUNT_W-1:0] COUNT_CAP =
		(MAX_PIXELS > 64'(COUNT_MAX)) ? COUNT_MAX : MAX_PIXELS[COUNT_W-1:0];

	typedef enum logic {
		OP_COUNT = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	typedef struct packed {
		logic               en;
		logic [LEVEL_W-1:0] addr;
	} glh_rd_t;

	typedef struct packed {
		logic               en;
		logic [LEVEL_W-1:0] addr;
		logic [COUNT_W-1:0] data;
	} glh_wr_t;

endpackage
`default_nettype wire

// ===== rtl/glh_store.sv =====
// Bin count memory with a registered read and per-bin valid bits.
`default_nettype none
module glh_store #(
	parameter int BIN_COUNT = glh_pkg::BIN_COUNT_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  glh_pkg::glh_rd_t             rd,
	input  glh_pkg::glh_wr_t             wr,
	output logic [glh_pkg::COUNT_W-1:0]  rd_data
);
	import glh_pkg::*;

	localparam int ADDR_W = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;

	logic [COUNT_W-1:0]   mem [BIN_COUNT];
	logic [BIN_COUNT-1:0] vld_q;
	logic [COUNT_W-1:0]   mem_rd_q;
	logic                 vld_rd_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr[ADDR_W-1:0]] <= wr.data;
		end
		if (rd.en) begin
			mem_rd_q <= mem[rd.addr[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr[ADDR_W-1:0]] <= 1'b1;
			end
			if (rd.en) begin
				vld_rd_q <= vld_q[rd.addr[ADDR_W-1:0]];
			end
		end
	end

	assign rd_data = vld_rd_q ? mem_rd_q : '0;

endmodule
`default_nettype wire

// ===== rtl/grey_level_histogram.sv =====
// Top level of the grey level histogram (256 bins by default) with bin readout and clear.
`default_nettype none
// Counts 8-bit grey pixels into BIN_COUNT bins held in one synchronous memory. Each request
// carries op in s_tuser (count pixel, or read and clear bin) and the level in s_tdata; each
// gives one result on m_tdata: the bin count after the increment, or before the clear.
// Levels at or beyond BIN_COUNT touch no bin and return zero. Counts saturate at the smaller
// of MAX_PIXELS and 2^21-1. One request is taken every cycle while the result side keeps up;
// each result passes the memory read stage and the update stage before it is registered on
// m_tdata, with the last written bin forwarded so back-to-back hits on one bin count
// correctly. Bins read as zero after reset without a clearing pass.
module grey_level_histogram #(
	parameter int BIN_COUNT = glh_pkg::BIN_COUNT_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	input  wire  [glh_pkg::LEVEL_W-1:0]      s_tdata,   // [7:0] level
	input  wire                              s_tuser,   // [0] op
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [glh_pkg::OUT_TDATA_W-1:0]  m_tdata    // [20:0] bin_count, [23:21] zero
);
	import glh_pkg::*;

	`include "assert_macros.svh"

	logic               v_s1;
	op_t                op_s1;
	logic [LEVEL_W-1:0] level_s1;

	logic               fwd_v_q;
	logic [LEVEL_W-1:0] fwd_addr_q;
	logic [COUNT_W-1:0] fwd_data_q;

	logic [COUNT_W-1:0] result_q;

	glh_rd_t            rd;
	glh_wr_t            wr;
	logic [COUNT_W-1:0] rd_data;
	logic               adv;
	logic               in_range;
	logic               fwd_hit;
	logic [COUNT_W-1:0] cur;
	logic [COUNT_W-1:0] inc;
	logic [COUNT_W-1:0] result;

	glh_store #(
		.BIN_COUNT(BIN_COUNT)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (rd),
		.wr      (wr),
		.rd_data (rd_data)
	);

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = !v_s1 || adv;

	assign rd.en   = s_tvalid && s_tready;
	assign rd.addr = s_tdata;

	assign in_range = 32'(level_s1) < BIN_COUNT;
	assign fwd_hit  = fwd_v_q && (fwd_addr_q == level_s1);
	assign cur      = fwd_hit ? fwd_data_q : rd_data;
	assign inc      = (cur < COUNT_CAP) ? cur + COUNT_W'(1) : cur;

	always_comb begin
		result = '0;
		if (in_range) begin
			case (op_s1)
				OP_COUNT: result = inc;
				OP_READ:  result = cur;
				default:  result = '0;
			endcase
		end
	end

	assign wr.en   = v_s1 && adv && in_range;
	assign wr.addr = level_s1;
	assign wr.data = (op_s1 == OP_READ) ? '0 : inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			fwd_v_q  <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (s_tready) begin
				v_s1 <= s_tvalid;
			end
			if (wr.en) begin
				fwd_v_q <= 1'b1;
			end
			if (adv) begin
				m_tvalid <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			op_s1    <= op_t'(s_tuser);
			level_s1 <= s_tdata;
		end
		if (wr.en) begin
			fwd_addr_q <= wr.addr;
			fwd_data_q <= wr.data;
		end
		if (adv && v_s1) begin
			result_q <= result;
		end
	end

	assign m_tdata = {(OUT_TDATA_W - COUNT_W)'(0), result_q};

	`GLH_ASSERT(a_hold_s1, v_s1 && !adv |=> v_s1 && $stable(level_s1) && $stable(op_s1), "stalled request changed")
	`GLH_ASSERT(a_cap, m_tvalid |-> result_q <= COUNT_CAP, "bin count above cap")
	`GLH_ASSERT(a_range, v_s1 && !in_range |-> result == '0, "out of range level gave a count")
	`GLH_ASSERT(a_write, wr.en |-> v_s1 && adv, "memory written without a completing request")

endmodule
`default_nettype wire
